// ----- sv/mds_pkg.sv -----
// Shared types and constants for the multibyte delimiter splitter.
package mds_pkg;

	localparam int MAX_DELIM_BYTES_DEF = 8;
	localparam int POSITION_BITS_DEF   = 16;

	localparam int DLEN_W      = 4;
	localparam int DBYTES_W    = 64;
	localparam int DSEL_W      = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int OUT_POS_W   = 16;
	localparam int OUTQ_DEPTH  = 4;
	localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W  = OUTQ_PTR_W + 1;

	localparam logic [DLEN_W-1:0]   DLEN_RESET   = 4'd1;
	localparam logic [DBYTES_W-1:0] DBYTES_RESET = 64'd44;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELIM_LEN   = 1'b0,
		REG_DELIM_BYTES = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_string;
	} in_word_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0] segment_start;
		logic [OUT_POS_W-1:0] segment_length;
		logic                 last_segment;
		logic                 overflow;
	} out_word_t;

	typedef struct packed {
		logic has_word;
		logic room_two;
	} outq_stat_t;

endpackage

// ----- sv/mds_cell.sv -----
// One byte cell of the delimiter compare chain.
module mds_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic       active,
	input  logic [7:0] byte_in,
	input  logic [7:0] want,
	output logic [7:0] byte_out,
	output logic       hit
);
	import mds_pkg::*;

	logic [7:0] byte_q;

	// held byte moves one place down the chain per accepted byte
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	// compare against the byte this cell will hold after the shift
	assign hit = !active || (byte_in == want);

endmodule

// ----- sv/mds_outq.sv -----
// Small result queue: up to two words in per cycle, one out.
module mds_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_a,
	input  mds_pkg::out_word_t  word_a,
	input  logic                push_b,
	input  mds_pkg::out_word_t  word_b,
	input  logic                pop,
	output mds_pkg::out_word_t  head,
	output mds_pkg::outq_stat_t stat
);
	import mds_pkg::*;

	out_word_t             mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_q;
	logic [OUTQ_PTR_W-1:0] rd_q;
	logic [OUTQ_CNT_W-1:0] cnt_q;
	logic [OUTQ_CNT_W-1:0] n_push;

	assign n_push = OUTQ_CNT_W'(push_a) + OUTQ_CNT_W'(push_b);

	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_q] <= word_a;
		end
		if (push_b) begin
			mem_q[wr_q + OUTQ_PTR_W'(1)] <= word_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[OUTQ_PTR_W-1:0];
			rd_q  <= rd_q + OUTQ_PTR_W'(pop);
			cnt_q <= cnt_q + n_push - OUTQ_CNT_W'(pop);
		end
	end

	assign head          = mem_q[rd_q];
	assign stat.has_word = (cnt_q != '0);
	assign stat.room_two = (cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH))
		else $error("result queue over capacity");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push_a && !push_b) |=> (cnt_q == $past(cnt_q) - OUTQ_CNT_W'(1)))
		else $error("result queue count did not drop on pop");

endmodule

// ----- sv/multibyte_delimiter_splitter_core.sv -----
// Top level: string splitter on a configurable multi-byte delimiter.
// A segment word is queued for out_word when the byte or end mark closing it is accepted.
// Throughput: one input word per cycle while in_stall is low; a word that yields
//   two segments (closing byte plus end mark) pushes two words into the 4-deep
//   result queue, which drains one word per cycle while out_stall is low and
//   stalls input when fewer than two slots are free.
// Reset: arst_n clears position, segment start, overflow and the queue;
//   delimiter registers return to length 1, byte 0x2C (comma).
module multibyte_delimiter_splitter_core #(
	parameter int MAX_DELIMITER_BYTES = mds_pkg::MAX_DELIM_BYTES_DEF,
	parameter int POSITION_BITS       = mds_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mds_pkg::in_word_t               in_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output mds_pkg::out_word_t              out_word,
	input  logic                            cfg_we,
	input  logic [mds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mds_pkg::DBYTES_W-1:0]    cfg_data
);
	import mds_pkg::*;

	localparam int PW = POSITION_BITS;

	// configuration registers
	logic [DLEN_W-1:0]   dlen_q;
	logic [DBYTES_W-1:0] dbytes_q;

	// per-string state
	logic [PW-1:0] pos_q;
	logic [PW-1:0] start_q;
	logic          ovf_q;

	logic              in_acc;
	logic [DLEN_W-1:0] act_len;
	logic              take;
	logic [PW-1:0]     pos_n;
	logic [PW-1:0]     start_after;
	logic              ovf_n;
	logic              tail_hit;
	logic              seg_hit;
	logic [PW:0]       min_end;
	logic [PW-1:0]     len_a;
	logic [PW-1:0]     len_b;
	out_word_t         word_a;
	out_word_t         word_b;
	outq_stat_t        qstat;
	logic              pop;

	logic [7:0]                   chain [MAX_DELIMITER_BYTES+1];
	logic [MAX_DELIMITER_BYTES-1:0] hits;

	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlen_q   <= DLEN_RESET;
			dbytes_q <= DBYTES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DELIM_LEN:   dlen_q   <= cfg_data[DLEN_W-1:0];
				REG_DELIM_BYTES: dbytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// lengths beyond the chain saturate to its size
	assign act_len = (dlen_q > DLEN_W'(MAX_DELIMITER_BYTES))
		? DLEN_W'(MAX_DELIMITER_BYTES) : dlen_q;

	// a byte arriving at the top position is dropped and flags overflow
	assign take  = in_word.byte_present && (pos_q != {PW{1'b1}});
	assign pos_n = take ? pos_q + PW'(1) : pos_q;
	assign ovf_n = ovf_q || (in_word.byte_present && !take);

	// chain: cell k holds the byte of age k; cell k checks delimiter byte
	// (length - 1 - k), cells past the active length always agree
	assign chain[0] = in_word.data_byte;

	for (genvar k = 0; k < MAX_DELIMITER_BYTES; k++) begin : g_cell
		logic [DSEL_W-1:0] sel;
		logic [7:0]        want;

		assign sel  = DSEL_W'(act_len - DLEN_W'(k) - DLEN_W'(1));
		assign want = dbytes_q[{sel, 3'b000} +: 8];

		mds_cell u_cell (
			.clk      (clk),
			.shift    (in_acc && take),
			.active   (act_len > DLEN_W'(k)),
			.byte_in  (chain[k]),
			.want     (want),
			.byte_out (chain[k+1]),
			.hit      (hits[k])
		);
	end

	assign tail_hit = &hits;

	// a match must lie wholly in this string and at or after the segment start
	assign min_end = {1'b0, start_q} + (PW+1)'(act_len);
	assign seg_hit = take && (act_len != '0) && tail_hit && ({1'b0, pos_n} >= min_end);

	assign start_after = seg_hit ? pos_n : start_q;
	assign len_a       = pos_n - PW'(act_len) - start_q;
	assign len_b       = pos_n - start_after;

	// positions are zero-extended, then cut to the 16-bit output fields
	always_comb begin
		logic [PW+OUT_POS_W-1:0] ext_s;
		logic [PW+OUT_POS_W-1:0] ext_l;
		logic [PW+OUT_POS_W-1:0] ext_bs;
		logic [PW+OUT_POS_W-1:0] ext_bl;
		ext_s  = {{OUT_POS_W{1'b0}}, start_q};
		ext_l  = {{OUT_POS_W{1'b0}}, len_a};
		ext_bs = {{OUT_POS_W{1'b0}}, start_after};
		ext_bl = {{OUT_POS_W{1'b0}}, len_b};

		word_a.segment_start  = ext_s[OUT_POS_W-1:0];
		word_a.segment_length = ext_l[OUT_POS_W-1:0];
		word_a.last_segment   = 1'b0;
		word_a.overflow       = ovf_n;

		word_b.segment_start  = ext_bs[OUT_POS_W-1:0];
		word_b.segment_length = ext_bl[OUT_POS_W-1:0];
		word_b.last_segment   = 1'b1;
		word_b.overflow       = ovf_n;
	end

	// end of string puts the string state back to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			ovf_q   <= 1'b0;
		end else if (in_acc) begin
			if (in_word.end_of_string) begin
				pos_q   <= '0;
				start_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				start_q <= start_after;
				ovf_q   <= ovf_n;
			end
		end
	end

	// the match segment goes first, the final segment after it
	logic push_a;
	logic push_b;

	assign push_a = in_acc && (seg_hit || in_word.end_of_string);
	assign push_b = in_acc && seg_hit && in_word.end_of_string;

	mds_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (push_a),
		.word_a (seg_hit ? word_a : word_b),
		.push_b (push_b),
		.word_b (word_b),
		.pop    (pop),
		.head   (out_word),
		.stat   (qstat)
	);

	assign out_valid = qstat.has_word;
	assign pop       = out_valid && !out_stall;
	assign in_stall  = !qstat.room_two;

	a_start_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		start_q <= pos_q)
		else $error("segment start ran past byte position");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_word.end_of_string) |=> (pos_q == '0 && start_q == '0 && !ovf_q))
		else $error("string state not cleared after end mark");

	a_hit_moves_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && seg_hit && !in_word.end_of_string) |=> (start_q == pos_q))
		else $error("segment start not moved to match end");

endmodule

// ----- verif/segment_checker.sv -----
// Segment checker: mirrors the splitter registers, predicts segment words, compares them.
module segment_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  mds_pkg::in_word_t              in_word,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  mds_pkg::out_word_t             out_word,
	input  logic                           cfg_we,
	input  logic [mds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mds_pkg::DBYTES_W-1:0]   cfg_data,
	output int unsigned                    mismatches,
	output int unsigned                    pending
);
	import mds_pkg::*;

	localparam int unsigned POS_LAST  = (1 << POSITION_BITS_DEF) - 1;
	localparam int unsigned MAX_PRINT = 60;

	logic [DLEN_W-1:0]   cfg_len;
	logic [DBYTES_W-1:0] delim_bytes;
	logic [7:0]          history [MAX_DELIM_BYTES_DEF];
	int unsigned         position;
	int unsigned         seg_start;
	bit                  overrun;
	out_word_t           segments_due [$];
	int unsigned         fail_count = 0;

	task note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_PRINT)
			$display("segment_checker: %s", msg);
	endtask

	task clear_string();
		int i;
		for (i = 0; i < MAX_DELIM_BYTES_DEF; i++)
			history[i] = 8'h00;
		position  = 0;
		seg_start = 0;
		overrun   = 1'b0;
	endtask

	task push_segment(int unsigned start, int unsigned len, bit last);
		out_word_t w;
		w.segment_start  = start[OUT_POS_W-1:0];
		w.segment_length = len[OUT_POS_W-1:0];
		w.last_segment   = last;
		w.overflow       = overrun;
		segments_due.push_back(w);
	endtask

	// Segments closed by one accepted word: a delimiter hit, then the end mark.
	task predict_segments(in_word_t w);
		int unsigned n;
		int unsigned i;
		bit          hit;
		if (w.byte_present) begin
			if (position >= POS_LAST) begin
				// full string: byte dropped, not counted or matched
				overrun = 1'b1;
			end else begin
				n = (cfg_len > MAX_DELIM_BYTES_DEF) ? MAX_DELIM_BYTES_DEF : cfg_len;
				for (i = MAX_DELIM_BYTES_DEF - 1; i > 0; i--)
					history[i] = history[i-1];
				history[0] = w.data_byte;
				position = (position + 1) & POS_LAST;
				// a hit counts only if it starts inside the open segment
				if (n > 0 && position >= n && position - n >= seg_start) begin
					hit = 1'b1;
					for (i = 0; i < n; i++)
						if (history[n-1-i] != delim_bytes[8*i +: 8])
							hit = 1'b0;
					if (hit) begin
						push_segment(seg_start, position - n - seg_start, 1'b0);
						seg_start = position;
					end
				end
			end
		end
		if (w.end_of_string) begin
			push_segment(seg_start, position - seg_start, 1'b1);
			clear_string();
		end
	endtask

	task check_segment(out_word_t got);
		out_word_t want;
		if (segments_due.size() == 0) begin
			note_failure($sformatf("unexpected segment start %0d length %0d",
				got.segment_start, got.segment_length));
		end else begin
			want = segments_due.pop_front();
			if (got.segment_start !== want.segment_start)
				note_failure($sformatf("segment_start got %0d want %0d",
					got.segment_start, want.segment_start));
			if (got.segment_length !== want.segment_length)
				note_failure($sformatf("segment_length got %0d want %0d",
					got.segment_length, want.segment_length));
			if (got.last_segment !== want.last_segment)
				note_failure($sformatf("last_segment got %b want %b",
					got.last_segment, want.last_segment));
			if (got.overflow !== want.overflow)
				note_failure($sformatf("overflow got %b want %b",
					got.overflow, want.overflow));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len     = DLEN_RESET;
			delim_bytes = DBYTES_RESET;
			clear_string();
			segments_due.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_reg_t'(cfg_index) == REG_DELIM_LEN)
					cfg_len = cfg_data[DLEN_W-1:0];
				else
					delim_bytes = cfg_data;
			end
			// a word accepted now cannot already have a result out
			if (out_valid && !out_stall)
				check_segment(out_word);
			if (in_valid && !in_stall)
				predict_segments(in_word);
		end
		mismatches <= fail_count;
		pending    <= segments_due.size();
	end

endmodule

// ----- verif/testbench.sv -----
// Testbench top: stimulus, handshake idling and verdict for the delimiter splitter.
module testbench;
	import mds_pkg::*;

	// about 1.5k words plus settling; far above any correct run
	localparam int unsigned CYCLE_LIMIT     = 60000;
	localparam int unsigned WORDS_PER_PHASE = 160;
	localparam int unsigned MAX_STRING_LEN  = 14;
	localparam logic [7:0]  COMMA           = 8'h2C;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	in_word_t                in_word   = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	out_word_t               out_word;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_DELIM_LEN;
	logic [DBYTES_W-1:0]     cfg_data  = '0;

	int unsigned             mismatches;
	int unsigned             pending;
	int unsigned             cycle_count = 0;
	int unsigned             words_sent  = 0;
	bit                      calm        = 1'b0;

	// stimulus-side copy of the delimiter, only used to shape string content
	int unsigned             cur_n     = 1;
	logic [DBYTES_W-1:0]     cur_bytes = DBYTES_RESET;

	multibyte_delimiter_splitter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	segment_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side backpressure: ~24% stall, none while calm.
	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 24);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Offer one word after a random idle gap and hold it until accepted.
	// Stall is read right after the edge, so it is the value the block sampled.
	task send_word(logic [7:0] b, bit present, bit fin);
		in_word_t w;
		w.data_byte     = b;
		w.byte_present  = present;
		w.end_of_string = fin;
		if (!calm) begin
			while ($urandom_range(99) < 24) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// words with neither byte nor end mark are ignored by the block
		if (present || fin)
			words_sent++;
	endtask

	// Drop valid and wait until every predicted segment has come out; the
	// extra cycles cover a trailing word that produces nothing.
	task settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers, back to back, only with the block idle.
	task set_delimiter(logic [DBYTES_W-1:0] len_word, logic [DBYTES_W-1:0] bytes);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_DELIM_LEN;
		cfg_data  <= len_word;
		@(posedge clk);
		cfg_index <= REG_DELIM_BYTES;
		cfg_data  <= bytes;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_n     = (len_word[DLEN_W-1:0] > MAX_DELIM_BYTES_DEF) ?
			MAX_DELIM_BYTES_DEF : len_word[DLEN_W-1:0];
		cur_bytes = bytes;
	endtask

	// First count bytes of the delimiter; short counts make broken matches.
	task send_delim_prefix(int unsigned count);
		int unsigned i;
		for (i = 0; i < count; i++)
			send_word(cur_bytes[8*i +: 8], 1'b1, 1'b0);
	endtask

	// About half the bytes drawn from the delimiter so partial and overlapping hits show up.
	function automatic logic [7:0] pick_byte();
		int unsigned sel;
		if (cur_n > 0 && $urandom_range(1) == 1) begin
			sel = $urandom_range(cur_n - 1);
			return cur_bytes[8*sel +: 8];
		end
		return 8'($urandom);
	endfunction

	// One well-formed string: random text, full delimiters, broken prefixes and
	// stray ignored words, closed by byte+end or a bare end mark.
	task send_random_string(int unsigned max_len);
		int unsigned len;
		int unsigned k;
		int unsigned r;
		int unsigned cut;
		len = $urandom_range(max_len);
		k   = 0;
		while (k < len) begin
			r = $urandom_range(99);
			if (cur_n > 0 && r < 22) begin
				send_delim_prefix(cur_n);
				k += cur_n;
			end else if (cur_n > 1 && r < 32) begin
				cut = $urandom_range(cur_n - 1, 1);
				send_delim_prefix(cut);
				k += cut;
			end else if (r < 36) begin
				send_word(8'($urandom), 1'b0, 1'b0);
			end else begin
				send_word(pick_byte(), 1'b1, 1'b0);
				k++;
			end
		end
		if ($urandom_range(1) == 1)
			send_word(pick_byte(), 1'b1, 1'b1);
		else
			send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	task run_phase(logic [DBYTES_W-1:0] len_word, logic [DBYTES_W-1:0] bytes, bit quiet);
		set_delimiter(len_word, bytes);
		calm       = quiet;
		words_sent = 0;
		while (words_sent < WORDS_PER_PHASE)
			send_random_string(MAX_STRING_LEN);
		calm = 1'b0;
	endtask

	initial begin
		int unsigned i;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed, reset delimiter (single comma) ----
		send_word(8'h00, 1'b0, 1'b1);          // empty string
		send_word(8'hFF, 1'b0, 1'b1);          // end mark, data ignored
		send_word(8'hA5, 1'b0, 1'b0);          // neither byte nor end
		send_word(COMMA, 1'b1, 1'b0);          // leading delimiter
		send_word(8'h00, 1'b0, 1'b1);          //   then empty last segment
		send_word(COMMA, 1'b1, 1'b0);
		send_word(COMMA, 1'b1, 1'b1);          // byte closes one, end closes another
		send_word(8'h00, 1'b1, 1'b0);          // byte extremes
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'h5A, 1'b0, 1'b0);          // ignored word mid-string
		send_word(COMMA, 1'b1, 1'b0);
		send_word(8'h80, 1'b1, 1'b0);
		send_word(8'h7F, 1'b1, 1'b1);

		// repeated-byte delimiter: matches must not overlap
		set_delimiter({32'($urandom), 28'($urandom), 4'd2},
			{32'($urandom), 16'($urandom), 16'h6161});
		for (i = 0; i < 5; i++)
			send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);

		// zero length: never matches
		set_delimiter({32'($urandom), 28'($urandom), 4'd0}, 64'd44);
		send_word(COMMA, 1'b1, 1'b0);
		send_word(COMMA, 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);

		// ---- random phases across delimiter settings ----
		run_phase({32'($urandom), 28'($urandom), 4'd2},
			{32'($urandom), 16'($urandom), 16'h6261}, 1'b0);
		run_phase({32'($urandom), 28'($urandom), 4'd8}, '1, 1'b0);
		run_phase({32'($urandom), 28'($urandom), 4'd1}, '0, 1'b0);
		run_phase({32'($urandom), 28'($urandom), 4'd0}, {$urandom, $urandom}, 1'b0);
		run_phase({32'($urandom), 28'($urandom), 4'd15}, {$urandom, $urandom}, 1'b0);
		// self-overlapping pattern a-b-a
		run_phase({32'($urandom), 28'($urandom), 4'd3},
			{32'($urandom), 8'($urandom), 24'h616261}, 1'b0);
		run_phase({32'($urandom), 28'($urandom), 4'd9}, {$urandom, $urandom}, 1'b0);
		run_phase({32'($urandom), 28'($urandom), 4'd4}, {$urandom, $urandom}, 1'b0);
		// back to the reset setting with no idling on either side
		run_phase({32'($urandom), 28'($urandom), 4'd1}, 64'd44, 1'b1);

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
